### hdl/glyph_text_rasterizer_macros.svh
// Assertion macros shared by the glyph text rasteriser modules.
// Each macro expects i_clk and i_rst_n to be visible in the module that uses it.
`ifndef GLYPH_TEXT_RASTERIZER_MACROS_SVH
`define GLYPH_TEXT_RASTERIZER_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define GTR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define GTR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/gtr_pkg.sv
// Package for the glyph text rasteriser: geometry constants, font table,
// sequencer states and the structs passed between the modules. No dependencies.
package gtr_pkg;

    localparam int SCREEN_WIDTH  = 240;
    localparam int SCREEN_HEIGHT = 135;
    localparam int MAX_SCALE     = 8;

    localparam int GLYPH_COLS   = 5;
    localparam int GLYPH_ROWS   = 7;
    localparam int GLYPH_COUNT  = 95;
    localparam int ADVANCE_DOTS = 6;
    localparam int LINE_DOTS    = 8;
    localparam int MASK_WIDTH   = 40;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_FIRST   = 8'd32;
    localparam logic [7:0] CHAR_LAST    = 8'd126;

    localparam int SCALE_W     = 4;
    localparam int COLOR_W     = 16;
    localparam int COORD_W     = 16;
    localparam int ALU_W       = 18;
    localparam int GLYPH_IDX_W = $clog2(GLYPH_COUNT);
    localparam int ROW_W       = $clog2(GLYPH_ROWS * MAX_SCALE + 1);
    localparam int MASK_IDX_W  = $clog2(MASK_WIDTH + 1);

    localparam logic signed [ALU_W-1:0] SCREEN_W_S   = ALU_W'(SCREEN_WIDTH);
    localparam logic signed [ALU_W-1:0] SCREEN_H_S   = ALU_W'(SCREEN_HEIGHT);
    localparam logic signed [ALU_W-1:0] MASK_WIDTH_S = ALU_W'(MASK_WIDTH);

    // Register select, taken from address bit 2.
    localparam logic REG_TEXT_COLOR = 1'b0;
    localparam logic REG_TEXT_SCALE = 1'b1;

    // Column-coded 5x7 font for codes 32..126. Column 0 sits in the low byte,
    // bit 0 of a column is the top dot row.
    localparam logic [MASK_WIDTH-1:0] FONT [GLYPH_COUNT] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h122A7F2A24, 40'h6264081323, 40'h5022554936, 40'h0000030500,
        40'h0041221C00, 40'h001C224100, 40'h14083E0814, 40'h08083E0808,
        40'h0000305000, 40'h0808080808, 40'h0000606000, 40'h0204081020,
        40'h3E4549513E, 40'h00407F4200, 40'h4649516142, 40'h314B454121,
        40'h107F121418, 40'h3945454527, 40'h3049494A3C, 40'h0305097101,
        40'h3649494936, 40'h1E29494906, 40'h0000363600, 40'h0000365600,
        40'h0041221408, 40'h1414141414, 40'h0814224100, 40'h0609510102,
        40'h3E41794932, 40'h7E1111117E, 40'h364949497F, 40'h224141413E,
        40'h1C2241417F, 40'h414949497F, 40'h010909097F, 40'h7A4949413E,
        40'h7F0808087F, 40'h00417F4100, 40'h013F414020, 40'h412214087F,
        40'h404040407F, 40'h7F020C027F, 40'h7F1008047F, 40'h3E4141413E,
        40'h060909097F, 40'h5E2151413E, 40'h462919097F, 40'h3149494946,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h4345495161, 40'h0041417F00,
        40'h2010080402, 40'h007F414100, 40'h0402010204, 40'h4040404040,
        40'h0004020100, 40'h7854545420, 40'h384444487F, 40'h2044444438,
        40'h7F48444438, 40'h1854545438, 40'h0201097E08, 40'h3E5252520C,
        40'h780404087F, 40'h00407D4400, 40'h003D444020, 40'h004428107F,
        40'h00407F4100, 40'h780418047C, 40'h780404087C, 40'h3844444438,
        40'h081414147C, 40'h7C18141408, 40'h080404087C, 40'h2054545448,
        40'h2040443F04, 40'h7C2040403C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h3C5050500C, 40'h444C546444, 40'h0041360800,
        40'h00007F0000, 40'h0008364100, 40'h081C2A0808
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NL,
        ST_CLIP_LO,
        ST_CLIP_HI,
        ST_ROW,
        ST_ADV
    } t_state;

    typedef struct packed {
        logic signed [ALU_W-1:0] a;
        logic signed [ALU_W-1:0] b;
        logic                    sub;
    } t_alu_req;

    typedef struct packed {
        logic signed [ALU_W-1:0]   sum;
        logic signed [COORD_W-1:0] sat;
    } t_alu_rsp;

    typedef struct packed {
        logic [GLYPH_IDX_W-1:0] glyph;
        logic [2:0]             glyph_row;
        logic [SCALE_W-1:0]     scale;
        logic [MASK_IDX_W-1:0]  clip_lo;
        logic [MASK_IDX_W-1:0]  clip_hi;
    } t_mask_req;

    // Scale 0 behaves as 1; anything above the maximum is held at the maximum.
    function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] raw);
        logic [SCALE_W-1:0] s;
        s = raw;
        if (raw == '0) begin
            s = SCALE_W'(1);
        end else if (raw > SCALE_W'(MAX_SCALE)) begin
            s = SCALE_W'(MAX_SCALE);
        end
        return s;
    endfunction

    // Clamp a clip bound to the mask bit range 0..MASK_WIDTH.
    function automatic logic [MASK_IDX_W-1:0] clamp_idx(input logic signed [ALU_W-1:0] v);
        logic [MASK_IDX_W-1:0] r;
        r = v[MASK_IDX_W-1:0];
        if (v < 0) begin
            r = '0;
        end else if (v > MASK_WIDTH_S) begin
            r = MASK_IDX_W'(MASK_WIDTH);
        end
        return r;
    endfunction

endpackage

### hdl/gtr_alu.sv
// Shared 18-bit add/subtract unit with 16-bit signed saturation.
// Depends on gtr_pkg for the request and response structs.
module gtr_alu (
    input  gtr_pkg::t_alu_req i_req,
    output gtr_pkg::t_alu_rsp o_rsp
);
    import gtr_pkg::*;

    localparam logic signed [ALU_W-1:0] S16_MAX = ALU_W'(32767);
    localparam logic signed [ALU_W-1:0] S16_MIN = -ALU_W'(32768);

    logic signed [ALU_W-1:0] sum;

    always_comb begin
        sum = i_req.sub ? (i_req.a - i_req.b) : (i_req.a + i_req.b);
        o_rsp.sum = sum;
        priority if (sum > S16_MAX) begin
            o_rsp.sat = COORD_W'(S16_MAX);
        end else if (sum < S16_MIN) begin
            o_rsp.sat = COORD_W'(S16_MIN);
        end else begin
            o_rsp.sat = sum[COORD_W-1:0];
        end
    end

endmodule

### hdl/gtr_mask.sv
// Builds one scaled, clipped pixel-row mask from the font table.
// Depends on gtr_pkg for the font, the widths and the request struct.
module gtr_mask (
    input  gtr_pkg::t_mask_req                  i_req,
    output logic [gtr_pkg::MASK_WIDTH-1:0]      o_mask
);
    import gtr_pkg::*;

    logic [7:0]            col;
    logic [MASK_WIDTH-1:0] ones;
    logic [MASK_WIDTH-1:0] dots;
    logic [MASK_WIDTH-1:0] clip;

    always_comb begin
        col  = '0;
        ones = (MASK_WIDTH'(1) << i_req.scale) - MASK_WIDTH'(1);
        dots = '0;
        // Each lit dot of the current glyph row becomes a run of scale pixels.
        for (int c = 0; c < GLYPH_COLS; c++) begin
            col = FONT[i_req.glyph][8*c +: 8];
            if (col[i_req.glyph_row]) begin
                dots = dots | (ones << (MASK_IDX_W'(c) * MASK_IDX_W'(i_req.scale)));
            end
        end
        for (int i = 0; i < MASK_WIDTH; i++) begin
            clip[i] = (MASK_IDX_W'(i) >= i_req.clip_lo) && (MASK_IDX_W'(i) < i_req.clip_hi);
        end
        o_mask = dots & clip;
    end

endmodule

### hdl/glyph_text_rasterizer.sv
// Glyph text rasteriser top level: APB register file, sequencer and span register.
// Depends on gtr_pkg, gtr_alu, gtr_mask and the assertion macro header.
//
// Usage: characters enter on the input channel (i_in_valid / o_in_ready), one
// transfer per character. A set start flag loads the origin into the cursor and
// the line start before the character is handled. Spans leave on the output
// channel (o_out_valid / i_out_ready), one per on-screen pixel row of the glyph,
// the final one of a character flagged by o_last_row.
// A printable character is accepted in the idle state, the CLIP_LO and CLIP_HI
// states set the horizontal clip window, the row state handles each glyph pixel
// row and the advance state moves the cursor. The clip, row, advance and newline
// states all use the single shared adder. A newline produces no spans. Rows below
// the screen end the character early; rows above it are still stepped through. The
// first span leaves the row state at the earliest after both clip states. If the
// receiver stalls, the sequencer holds on the pending row until the span register
// frees; nothing is dropped. The user must write colour and scale through the APB
// port only while the block is idle; the block does not enforce this. Reset clears
// the cursor and line start to zero, sets the colour to white and the scale to one.
`include "glyph_text_rasterizer_macros.svh"

module glyph_text_rasterizer (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Character channel
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic                                  i_start_of_text,
    input  logic signed [gtr_pkg::COORD_W-1:0]    i_origin_x,
    input  logic signed [gtr_pkg::COORD_W-1:0]    i_origin_y,
    input  logic [7:0]                            i_char_code,
    // Span channel
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [7:0]                            o_row_y,
    output logic signed [gtr_pkg::COORD_W-1:0]    o_span_x,
    output logic [gtr_pkg::MASK_WIDTH-1:0]        o_pixel_mask,
    output logic [gtr_pkg::COLOR_W-1:0]           o_pixel_color,
    output logic                                  o_last_row,
    // Register port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);
    import gtr_pkg::*;

    // Registers
    t_state                    r_state, n_state;
    logic [COLOR_W-1:0]        r_color, n_color;
    logic [SCALE_W-1:0]        r_scale, n_scale;
    logic signed [COORD_W-1:0] r_cx, n_cx;
    logic signed [COORD_W-1:0] r_cy, n_cy;
    logic signed [COORD_W-1:0] r_lsx, n_lsx;
    logic [GLYPH_IDX_W-1:0]    r_glyph, n_glyph;
    logic [SCALE_W-1:0]        r_s, n_s;
    logic [ROW_W-1:0]          r_rows_m1, n_rows_m1;
    logic [ROW_W-1:0]          r_row, n_row;
    logic [SCALE_W-1:0]        r_sub, n_sub;
    logic [2:0]                r_glyph_row, n_glyph_row;
    logic [MASK_IDX_W-1:0]     r_clip_lo, n_clip_lo;
    logic [MASK_IDX_W-1:0]     r_clip_hi, n_clip_hi;
    logic                      r_out_valid, n_out_valid;
    logic [7:0]                r_out_row_y;
    logic signed [COORD_W-1:0] r_out_span_x;
    logic [MASK_WIDTH-1:0]     r_out_mask;
    logic [COLOR_W-1:0]        r_out_color;
    logic                      r_out_last;

    // Control
    logic                  in_xfer;
    logic                  cfg_write;
    logic                  out_free;
    logic                  emit;
    logic                  row_step;
    logic                  row_done;
    logic                  row_above;
    logic                  row_below;
    logic                  row_last;
    logic                  row_final;
    logic [SCALE_W-1:0]    scale_now;
    t_alu_req              alu_req;
    t_alu_rsp              alu_rsp;
    t_mask_req             mask_req;
    logic [MASK_WIDTH-1:0] mask;

    gtr_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    gtr_mask u_mask (
        .i_req  (mask_req),
        .o_mask (mask)
    );

    assign in_xfer   = i_in_valid && o_in_ready;
    assign cfg_write = psel && penable && pwrite;
    assign out_free  = !r_out_valid || i_out_ready;
    assign scale_now = eff_scale(r_scale);

    // In the row state the adder yields the screen y of the current row.
    assign row_above = alu_rsp.sum < 0;
    assign row_below = alu_rsp.sum >= SCREEN_H_S;
    assign row_final = r_row == r_rows_m1;
    assign row_last  = row_final || (alu_rsp.sum == SCREEN_H_S - ALU_W'(1));

    assign mask_req.glyph     = r_glyph;
    assign mask_req.glyph_row = r_glyph_row;
    assign mask_req.scale     = r_s;
    assign mask_req.clip_lo   = r_clip_lo;
    assign mask_req.clip_hi   = r_clip_hi;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = (i_char_code == CHAR_NEWLINE) ? ST_NL : ST_CLIP_LO;
                end
            end
            ST_NL:      n_state = ST_IDLE;
            ST_CLIP_LO: n_state = ST_CLIP_HI;
            ST_CLIP_HI: n_state = ST_ROW;
            ST_ROW: begin
                if (row_below || row_done) begin
                    n_state = ST_ADV;
                end
            end
            ST_ADV:     n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // State outputs: adder operands and row control
    always_comb begin
        o_in_ready  = 1'b0;
        emit        = 1'b0;
        row_step    = 1'b0;
        row_done    = 1'b0;
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;
        unique case (r_state)
            ST_IDLE: o_in_ready = 1'b1;
            ST_NL: begin
                alu_req.a = ALU_W'(r_cy);
                alu_req.b = ALU_W'(r_s * LINE_DOTS);
            end
            ST_CLIP_LO: begin
                alu_req.b   = ALU_W'(r_cx);
                alu_req.sub = 1'b1;
            end
            ST_CLIP_HI: begin
                alu_req.a   = SCREEN_W_S;
                alu_req.b   = ALU_W'(r_cx);
                alu_req.sub = 1'b1;
            end
            ST_ROW: begin
                alu_req.a = ALU_W'(r_cy);
                alu_req.b = ALU_W'(r_row);
                if (!row_below) begin
                    if (row_above) begin
                        row_step = !row_final;
                        row_done = row_final;
                    end else if (out_free) begin
                        emit     = 1'b1;
                        row_step = !row_last;
                        row_done = row_last;
                    end
                end
            end
            ST_ADV: begin
                alu_req.a = ALU_W'(r_cx);
                alu_req.b = ALU_W'(r_s * ADVANCE_DOTS);
            end
            default: o_in_ready = 1'b0;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_color     = r_color;
        n_scale     = r_scale;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_lsx       = r_lsx;
        n_glyph     = r_glyph;
        n_s         = r_s;
        n_rows_m1   = r_rows_m1;
        n_row       = r_row;
        n_sub       = r_sub;
        n_glyph_row = r_glyph_row;
        n_clip_lo   = r_clip_lo;
        n_clip_hi   = r_clip_hi;
        n_out_valid = r_out_valid && !i_out_ready;

        if (cfg_write) begin
            if (paddr[2] == REG_TEXT_COLOR) begin
                n_color = pwdata[COLOR_W-1:0];
            end else begin
                n_scale = pwdata[SCALE_W-1:0];
            end
        end

        if (in_xfer) begin
            if (i_start_of_text) begin
                n_cx  = i_origin_x;
                n_lsx = i_origin_x;
                n_cy  = i_origin_y;
            end
            // Codes outside the printable range draw the blank space glyph.
            if (i_char_code >= CHAR_FIRST && i_char_code <= CHAR_LAST) begin
                n_glyph = GLYPH_IDX_W'(i_char_code - CHAR_FIRST);
            end else begin
                n_glyph = '0;
            end
            n_s         = scale_now;
            n_rows_m1   = ROW_W'(scale_now * GLYPH_ROWS) - ROW_W'(1);
            n_row       = '0;
            n_sub       = '0;
            n_glyph_row = '0;
        end

        if (r_state == ST_NL) begin
            n_cy = alu_rsp.sat;
            n_cx = r_lsx;
        end
        if (r_state == ST_CLIP_LO) begin
            n_clip_lo = clamp_idx(alu_rsp.sum);
        end
        if (r_state == ST_CLIP_HI) begin
            n_clip_hi = clamp_idx(alu_rsp.sum);
        end
        if (r_state == ST_ADV) begin
            n_cx = alu_rsp.sat;
        end

        if (row_step) begin
            n_row = r_row + ROW_W'(1);
            // Each glyph dot row repeats for scale pixel rows.
            if (r_sub == r_s - SCALE_W'(1)) begin
                n_sub       = '0;
                n_glyph_row = r_glyph_row + 3'd1;
            end else begin
                n_sub = r_sub + SCALE_W'(1);
            end
        end

        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_color     <= '1;
            r_scale     <= SCALE_W'(1);
            r_cx        <= '0;
            r_cy        <= '0;
            r_lsx       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_color     <= n_color;
            r_scale     <= n_scale;
            r_cx        <= n_cx;
            r_cy        <= n_cy;
            r_lsx       <= n_lsx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_glyph     <= n_glyph;
        r_s         <= n_s;
        r_rows_m1   <= n_rows_m1;
        r_row       <= n_row;
        r_sub       <= n_sub;
        r_glyph_row <= n_glyph_row;
        r_clip_lo   <= n_clip_lo;
        r_clip_hi   <= n_clip_hi;
        if (emit) begin
            r_out_row_y  <= alu_rsp.sum[7:0];
            r_out_span_x <= r_cx;
            r_out_mask   <= mask;
            r_out_color  <= r_color;
            r_out_last   <= row_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_row_y       = r_out_row_y;
    assign o_span_x      = r_out_span_x;
    assign o_pixel_mask  = r_out_mask;
    assign o_pixel_color = r_out_color;
    assign o_last_row    = r_out_last;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TEXT_SCALE) ? 32'(r_scale) : 32'(r_color);

    `GTR_ASSERT_IMPL(a_row_in_range, r_state == ST_ROW, r_row <= r_rows_m1, "row counter passed the final glyph row")
    `GTR_ASSERT_IMPL(a_dot_row_in_range, r_state == ST_ROW, (r_sub < r_s) && (r_glyph_row < 3'(GLYPH_ROWS)), "glyph dot row counters out of step")
    `GTR_ASSERT_IMPL(a_clip_bounds, r_state == ST_ROW, (r_clip_lo <= MASK_IDX_W'(MASK_WIDTH)) && (r_clip_hi <= MASK_IDX_W'(MASK_WIDTH)), "clip window outside the mask")
    `GTR_ASSERT_NEXT(a_newline_return, r_state == ST_NL, (r_state == ST_IDLE) && (r_cx == $past(r_lsx)), "newline did not return to the line start")

endmodule

### tb/glyph_span_checker.sv
// Span checker for the glyph text rasteriser: watches the register port and both channels,
// predicts the spans of every accepted character and compares them in order.
// Depends on gtr_pkg for widths and character codes.
`timescale 1ns / 100ps

module glyph_span_checker (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  i_in_ready,
    input  logic                                  i_start_of_text,
    input  logic signed [gtr_pkg::COORD_W-1:0]    i_origin_x,
    input  logic signed [gtr_pkg::COORD_W-1:0]    i_origin_y,
    input  logic [7:0]                            i_char_code,
    input  logic                                  i_out_valid,
    input  logic                                  i_out_ready,
    input  logic [7:0]                            i_row_y,
    input  logic signed [gtr_pkg::COORD_W-1:0]    i_span_x,
    input  logic [gtr_pkg::MASK_WIDTH-1:0]        i_pixel_mask,
    input  logic [gtr_pkg::COLOR_W-1:0]           i_pixel_color,
    input  logic                                  i_last_row,
    input  logic                                  i_psel,
    input  logic                                  i_penable,
    input  logic                                  i_pwrite,
    input  logic [2:0]                            i_paddr,
    input  logic [31:0]                           i_pwdata,
    input  logic                                  i_pready,
    output int                                    o_pending,
    output int                                    o_fail_count
);
    import gtr_pkg::*;

    typedef struct packed {
        logic [7:0]                row;
        logic signed [COORD_W-1:0] x;
        logic [MASK_WIDTH-1:0]     mask;
        logic [COLOR_W-1:0]        color;
        logic                      last;
    } t_span;

    // Font columns for codes 32..126, leftmost column in the top byte and the top dot
    // row in bit 0 of each column.
    localparam logic [39:0] GLYPH_COLUMNS [95] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
        40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
        40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
        40'h0001020400, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
        40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
        40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
        40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
        40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
        40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
        40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
        40'h00007F0000, 40'h0041360800, 40'h08082A1C08
    };

    logic [COLOR_W-1:0] color_reg;
    logic [SCALE_W-1:0] scale_reg;
    int                 pen_x;
    int                 pen_y;
    int                 line_left_x;
    int                 mismatches;
    t_span              expected_spans [$];

    function automatic int clamp16(input int v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    task automatic predict_spans(input logic start, input logic signed [COORD_W-1:0] ox,
                                 input logic signed [COORD_W-1:0] oy, input logic [7:0] code);
        int s, g, lo, hi, y, gr, last_y;
        logic [MASK_WIDTH-1:0] window, bits;
        t_span sp;
        s = (scale_reg == 0) ? 1 : ((scale_reg > MAX_SCALE) ? MAX_SCALE : int'(scale_reg));
        if (start) begin
            pen_x = ox;
            line_left_x = pen_x;
            pen_y = oy;
        end
        if (code == CHAR_NEWLINE) begin
            pen_y = clamp16(pen_y + 8 * s);
            pen_x = line_left_x;
            return;
        end
        g = (code >= CHAR_FIRST && code <= CHAR_LAST) ? int'(code - CHAR_FIRST) : 0;

        // Only mask bits whose pixel lands between x = 0 and the right screen edge survive.
        lo = (-pen_x < 0) ? 0 : -pen_x;
        hi = (SCREEN_WIDTH - pen_x > MASK_WIDTH) ? MASK_WIDTH : SCREEN_WIDTH - pen_x;
        window = '0;
        for (int b = 0; b < MASK_WIDTH; b++) begin
            if (b >= lo && b < hi) window[b] = 1'b1;
        end

        // Visible rows are contiguous, so the final span is the lower of the glyph
        // bottom and the screen bottom.
        last_y = (pen_y + 7 * s - 1 < SCREEN_HEIGHT - 1) ? pen_y + 7 * s - 1
                                                         : SCREEN_HEIGHT - 1;
        for (int r = 0; r < 7 * s; r++) begin
            y = pen_y + r;
            if (y < 0 || y >= SCREEN_HEIGHT) continue;
            gr = r / s;
            bits = '0;
            for (int c = 0; c < 5; c++) begin
                if (GLYPH_COLUMNS[g][8 * (4 - c) + gr]) begin
                    bits |= ((40'd1 << s) - 40'd1) << (c * s);
                end
            end
            sp.row   = 8'(y);
            sp.x     = 16'(pen_x);
            sp.mask  = bits & window;
            sp.color = color_reg;
            sp.last  = (y == last_y);
            expected_spans.push_back(sp);
        end
        pen_x = clamp16(pen_x + 6 * s);
    endtask

    task automatic check_span();
        t_span want;
        if (expected_spans.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected span: row %0d x %0d mask %h color %h last %b",
                         i_row_y, i_span_x, i_pixel_mask, i_pixel_color, i_last_row);
            end
            return;
        end
        want = expected_spans.pop_front();
        if (i_row_y != want.row || i_span_x != want.x || i_pixel_mask != want.mask ||
            i_pixel_color != want.color || i_last_row != want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("span mismatch: expected row %0d x %0d mask %h color %h last %b",
                         want.row, want.x, want.mask, want.color, want.last);
                $display("               actual   row %0d x %0d mask %h color %h last %b",
                         i_row_y, i_span_x, i_pixel_mask, i_pixel_color, i_last_row);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            color_reg   = 16'hFFFF;
            scale_reg   = 4'd1;
            pen_x       = 0;
            pen_y       = 0;
            line_left_x = 0;
            mismatches  = 0;
            expected_spans.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[2])
                    REG_TEXT_COLOR: color_reg = i_pwdata[COLOR_W-1:0];
                    REG_TEXT_SCALE: scale_reg = i_pwdata[SCALE_W-1:0];
                endcase
            end
            // Spans never belong to a character accepted on the same edge, so the
            // comparison can come first.
            if (i_out_valid && i_out_ready) check_span();
            if (i_in_valid && i_in_ready) begin
                predict_spans(i_start_of_text, i_origin_x, i_origin_y, i_char_code);
            end
        end
        o_pending    <= expected_spans.size();
        o_fail_count <= mismatches;
    end

endmodule

### tb/tb.sv
// Testbench top for glyph_text_rasterizer: clock, reset, register writes and character
// stimulus under varying flow control. Depends on gtr_pkg, the rasteriser and glyph_span_checker.
`timescale 1ns / 100ps

module tb;
    import gtr_pkg::*;

    localparam logic [2:0] ADDR_TEXT_COLOR = {REG_TEXT_COLOR, 2'b00};
    localparam logic [2:0] ADDR_TEXT_SCALE = {REG_TEXT_SCALE, 2'b00};
    localparam int         SETTLE_CYCLES   = 80;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_ready;
    logic                       start_of_text;
    logic signed [COORD_W-1:0]  origin_x;
    logic signed [COORD_W-1:0]  origin_y;
    logic [7:0]                 char_code;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [7:0]                 row_y;
    logic signed [COORD_W-1:0]  span_x;
    logic [MASK_WIDTH-1:0]      pixel_mask;
    logic [COLOR_W-1:0]         pixel_color;
    logic                       last_row;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [2:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;
    int                         pending;
    int                         fail_count;
    int                         sender_idle_pct = 0;
    int                         recv_stall_pct  = 0;

    glyph_text_rasterizer uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_ready      (in_ready),
        .i_start_of_text (start_of_text),
        .i_origin_x      (origin_x),
        .i_origin_y      (origin_y),
        .i_char_code     (char_code),
        .o_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .o_row_y         (row_y),
        .o_span_x        (span_x),
        .o_pixel_mask    (pixel_mask),
        .o_pixel_color   (pixel_color),
        .o_last_row      (last_row),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    glyph_span_checker span_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_start_of_text (start_of_text),
        .i_origin_x      (origin_x),
        .i_origin_y      (origin_y),
        .i_char_code     (char_code),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_row_y         (row_y),
        .i_span_x        (span_x),
        .i_pixel_mask    (pixel_mask),
        .i_pixel_color   (pixel_color),
        .i_last_row      (last_row),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_pending       (pending),
        .o_fail_count    (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        #8_000_000;
        $display("glyph_text_rasterizer regression: fail");
        $finish;
    end

    task automatic send_char(input logic start, input logic [15:0] ox, input logic [15:0] oy,
                             input logic [7:0] code);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        start_of_text <= start;
        origin_x      <= ox;
        origin_y      <= oy;
        char_code     <= code;
        do @(posedge clk); while (!in_ready);
    endtask

    // Holds the sender back until every predicted span has been taken, then lets
    // the sequencer finish any character whose rows were all off screen.
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [7:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 8) return CHAR_NEWLINE;
        if (r < 14) return 8'($urandom_range(255));
        return 8'($urandom_range(CHAR_LAST, CHAR_FIRST));
    endfunction

    // Mostly lines of text placed around the visible area, with occasional
    // fully random characters in between.
    task automatic run_text(input int n_items);
        int sent, run_len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 80) begin
                run_len = $urandom_range(12, 3);
                send_char(1'b1, 16'(int'($urandom_range(300)) - 50),
                          16'(int'($urandom_range(200)) - 60), pick_code());
                for (int k = 1; k < run_len; k++) begin
                    send_char(1'b0, 16'($urandom), 16'($urandom), pick_code());
                end
                sent += run_len;
            end else begin
                send_char(1'($urandom_range(1)), 16'($urandom), 16'($urandom),
                          8'($urandom_range(255)));
                sent++;
            end
        end
    endtask

    initial begin
        logic [3:0]  scale_plan [8];
        logic [15:0] colour;
        scale_plan    = '{4'd1, 4'd8, 4'd2, 4'd0, 4'd15, 4'd3, 4'd5, 4'd9};
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        start_of_text = 1'b0;
        origin_x      = '0;
        origin_y      = '0;
        char_code     = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset colour and scale: glyph range ends, non-printable codes, newlines,
        // clipping on every side and cursor saturation.
        send_char(1'b1, 16'd0, 16'd0, "A");
        send_char(1'b0, 16'd0, 16'd0, "~");
        send_char(1'b0, 16'd0, 16'd0, " ");
        send_char(1'b0, 16'd0, 16'd0, 8'd31);
        send_char(1'b0, 16'd0, 16'd0, 8'd127);
        send_char(1'b0, 16'd0, 16'd0, 8'd255);
        send_char(1'b0, 16'd0, 16'd0, 8'd0);
        send_char(1'b1, 16'd10, 16'd20, CHAR_NEWLINE);
        send_char(1'b0, 16'd0, 16'd0, "g");
        send_char(1'b0, 16'd0, 16'd0, CHAR_NEWLINE);
        send_char(1'b1, -16'sd3, -16'sd4, "M");
        send_char(1'b1, 16'd237, 16'd130, "W");
        send_char(1'b1, 16'h8000, 16'h8000, "H");
        send_char(1'b1, 16'h7FFF, 16'h7FFF, "#");
        send_char(1'b0, 16'hFFFF, 16'hFFFF, "X");
        send_char(1'b1, 16'd0, 16'h7FFF, CHAR_NEWLINE);
        settle();

        write_reg(ADDR_TEXT_SCALE, 32'd8);
        write_reg(ADDR_TEXT_COLOR, 32'h0000_0000);
        send_char(1'b1, 16'd200, 16'd100, "@");
        send_char(1'b1, -16'sd20, -16'sd30, "8");
        settle();
        write_reg(ADDR_TEXT_SCALE, 32'd0);
        write_reg(ADDR_TEXT_COLOR, 32'h0000_A5A5);
        send_char(1'b1, 16'd5, 16'd5, "!");
        send_char(1'b0, 16'd0, 16'd0, CHAR_NEWLINE);
        send_char(1'b0, 16'd0, 16'd0, "j");
        settle();
        write_reg(ADDR_TEXT_SCALE, 32'd15);
        send_char(1'b1, 16'd100, 16'd60, "%");

        for (int phase = 0; phase < 8; phase++) begin
            settle();
            colour = (phase == 0) ? 16'h0000 : (phase == 1) ? 16'hFFFF : 16'($urandom);
            write_reg(ADDR_TEXT_COLOR, {16'($urandom), colour});
            write_reg(ADDR_TEXT_SCALE, 32'(scale_plan[phase]));
            case (phase % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin sender_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            run_text(60);
        end

        settle();
        if (fail_count == 0) begin
            $display("glyph_text_rasterizer regression: pass");
        end else begin
            $display("glyph_text_rasterizer regression: fail");
        end
        $finish;
    end

endmodule
